// ===== rtl/spi_pkg.sv =====
// ----------------------------------------------------------------------------
// spi_pkg: shared types and constants for the segment/plane intersection block
// widths, register indexes and the divider cell handoff record
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int unsigned CoordWidth    = 32;
  localparam int unsigned FractionBits  = 16;
  localparam int unsigned NormWidth     = 32;
  localparam int unsigned OffsetWidth   = 64;
  localparam int unsigned QuotBits      = 32;
  localparam int unsigned CfgIdxWidth   = 2;
  // products are 64 bits, six of them plus the offset fit in 68 bits
  localparam int unsigned SumWidth      = 68;

  localparam logic [CfgIdxWidth-1:0] RegNormalX = 2'd0;
  localparam logic [CfgIdxWidth-1:0] RegNormalY = 2'd1;
  localparam logic [CfgIdxWidth-1:0] RegNormalZ = 2'd2;
  localparam logic [CfgIdxWidth-1:0] RegOffset  = 2'd3;

  localparam logic [NormWidth-1:0]   NormalZReset = 32'sd65536;

  // coordinate record carried along the chain (start point and ray)
  typedef struct packed {
    logic signed [CoordWidth-1:0] p1_x;
    logic signed [CoordWidth-1:0] p1_y;
    logic signed [CoordWidth-1:0] p1_z;
    logic signed [CoordWidth:0]   ray_x;
    logic signed [CoordWidth:0]   ray_y;
    logic signed [CoordWidth:0]   ray_z;
  } seg_t;

  // what one restoring division cell hands its neighbor
  typedef struct packed {
    logic                valid;
    logic                hit;
    logic [SumWidth-1:0] rem;
    logic [SumWidth-1:0] den;
    logic [QuotBits-1:0] quot;
    seg_t                seg;
  } div_t;

endpackage

// ===== rtl/spi_div_cell.sv =====
// ----------------------------------------------------------------------------
// spi_div_cell: one restoring division step
// shifts the remainder, subtracts the denominator and keeps one quotient bit
// ----------------------------------------------------------------------------
module spi_div_cell import spi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  div_t in_i,
  output div_t out_o
);

  div_t out_q, out_d;
  logic valid_q;
  logic [SumWidth-1:0] shl;

  always_comb begin
    shl = {in_i.rem[SumWidth-2:0], 1'b0};
    out_d = in_i;
    if (shl >= in_i.den) begin
      out_d.rem  = shl - in_i.den;
      out_d.quot = {in_i.quot[QuotBits-2:0], 1'b1};
    end else begin
      out_d.rem  = shl;
      out_d.quot = {in_i.quot[QuotBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    out_o       = out_q;
    out_o.valid = valid_q;
  end

endmodule

// ===== rtl/spi_front.sv =====
// ----------------------------------------------------------------------------
// spi_front: dot products and the range test on t
// three registered stages: products, sums, sign fold and compare
// ----------------------------------------------------------------------------
module spi_front import spi_pkg::*; #(
  parameter int unsigned COORD_WIDTH = CoordWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] start_z_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_z_i,
  input  logic signed [NormWidth-1:0]   normal_x_i,
  input  logic signed [NormWidth-1:0]   normal_y_i,
  input  logic signed [NormWidth-1:0]   normal_z_i,
  input  logic signed [OffsetWidth-1:0] plane_offset_i,
  output div_t                          out_o
);

  localparam int unsigned PW = NormWidth + COORD_WIDTH;

  // stage 1: six products
  logic signed [PW-1:0] a_x_q, a_y_q, a_z_q, b_x_q, b_y_q, b_z_q;
  logic signed [OffsetWidth-1:0] off1_q;
  seg_t seg1_q, seg2_q, seg3_q, seg_d;
  logic v1_q, v2_q, v3_q;

  // stage 2: numerator and denominator
  logic signed [SumWidth-1:0] num_q, den_q, num_d, den_d;

  // stage 3 values
  logic [SumWidth-1:0] rem_q, dmag_q, nabs, dabs;
  logic hit_q, hit_d;

  always_comb begin
    seg_d.p1_x  = CoordWidth'(start_x_i);
    seg_d.p1_y  = CoordWidth'(start_y_i);
    seg_d.p1_z  = CoordWidth'(start_z_i);
    seg_d.ray_x = (CoordWidth+1)'($signed(end_x_i)) - (CoordWidth+1)'($signed(start_x_i));
    seg_d.ray_y = (CoordWidth+1)'($signed(end_y_i)) - (CoordWidth+1)'($signed(start_y_i));
    seg_d.ray_z = (CoordWidth+1)'($signed(end_z_i)) - (CoordWidth+1)'($signed(start_z_i));
  end

  always_comb begin
    num_d = -SumWidth'(off1_q) - SumWidth'(a_x_q) - SumWidth'(a_y_q) - SumWidth'(a_z_q);
    den_d = SumWidth'(b_x_q) + SumWidth'(b_y_q) + SumWidth'(b_z_q)
          - SumWidth'(a_x_q) - SumWidth'(a_y_q) - SumWidth'(a_z_q);
  end

  always_comb begin
    nabs  = num_q[SumWidth-1] ? SumWidth'(-num_q) : SumWidth'(num_q);
    dabs  = den_q[SumWidth-1] ? SumWidth'(-den_q) : SumWidth'(den_q);
    hit_d = (den_q != '0) && (num_q != '0) && (num_q[SumWidth-1] == den_q[SumWidth-1])
          && (nabs < dabs);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_x_q  <= normal_x_i * start_x_i;
      a_y_q  <= normal_y_i * start_y_i;
      a_z_q  <= normal_z_i * start_z_i;
      b_x_q  <= normal_x_i * end_x_i;
      b_y_q  <= normal_y_i * end_y_i;
      b_z_q  <= normal_z_i * end_z_i;
      off1_q <= plane_offset_i;
      seg1_q <= seg_d;
      num_q  <= num_d;
      den_q  <= den_d;
      seg2_q <= seg1_q;
      rem_q  <= nabs;
      dmag_q <= dabs;
      hit_q  <= hit_d;
      seg3_q <= seg2_q;
    end
  end

  always_comb begin
    out_o.valid = v3_q;
    out_o.hit   = hit_q;
    out_o.rem   = rem_q;
    out_o.den   = dmag_q;
    out_o.quot  = '0;
    out_o.seg   = seg3_q;
  end

endmodule

// ===== rtl/spi_back.sv =====
// ----------------------------------------------------------------------------
// spi_back: point = p1 + floor(ray * t)
// two stages: partial products of |ray| by t, then floor fix and add
// ----------------------------------------------------------------------------
module spi_back import spi_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  div_t                         in_i,
  output logic                         valid_o,
  output logic                         hit_o,
  output logic signed [CoordWidth-1:0] point_x_o,
  output logic signed [CoordWidth-1:0] point_y_o,
  output logic signed [CoordWidth-1:0] point_z_o
);

  localparam int unsigned RW = CoordWidth + 1;
  localparam int unsigned MW = RW + QuotBits;

  logic [2:0][RW-1:0] mag;
  logic [2:0]         neg_d, neg_q;
  logic [2:0][MW-1:0] prod_q;
  logic [2:0][CoordWidth-1:0] base_q;
  logic [2:0][CoordWidth-1:0] pt_d;
  logic [RW-1:0] step;
  logic v_q, hit_q;
  logic [2:0][RW-1:0] ray;

  assign ray = {in_i.seg.ray_z, in_i.seg.ray_y, in_i.seg.ray_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = ray[i][RW-1];
      mag[i]   = neg_d[i] ? RW'(-ray[i]) : ray[i];
    end
  end

  always_comb begin
    step = '0;
    for (int i = 0; i < 3; i++) begin
      step = prod_q[i][MW-1:QuotBits]
           + RW'(neg_q[i] && (prod_q[i][QuotBits-1:0] != '0));
      pt_d[i] = neg_q[i] ? base_q[i] - step[CoordWidth-1:0]
                         : base_q[i] + step[CoordWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= 1'b0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      v_q     <= in_i.valid;
      valid_o <= v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= MW'(mag[i]) * MW'(in_i.quot);
      end
      neg_q  <= neg_d;
      base_q <= {in_i.seg.p1_z, in_i.seg.p1_y, in_i.seg.p1_x};
      hit_q  <= in_i.hit;
      hit_o  <= hit_q;
      point_x_o <= hit_q ? pt_d[0] : '0;
      point_y_o <= hit_q ? pt_d[1] : '0;
      point_z_o <= hit_q ? pt_d[2] : '0;
    end
  end

endmodule

// ===== rtl/segment_plane_intersection.sv =====
// ----------------------------------------------------------------------------
// segment_plane_intersection: streaming segment versus plane crossing
// t from a chain of 32 restoring division cells, point from p1 + ray*t
// ----------------------------------------------------------------------------
//  channel  | dir | handshake           | payload
//  s_axis   | in  | tvalid/tready       | tdata: start_x..end_z (6 x 32)
//  m_axis   | out | tvalid/tready       | tdata: point_x,y,z; tuser: hit
//  cfg      | in  | cfg_valid/cfg_ready | cfg_index (2), cfg_data (64)
//
//  one segment per cycle while m_axis does not stall the pipe
//  the 32 division cells each resolve one bit of t
//  a stall on m_axis freezes the whole pipe (a single enable)
//  reset clears valid bits and loads the register reset values
// ----------------------------------------------------------------------------
module segment_plane_intersection import spi_pkg::*; #(
  parameter int unsigned COORD_WIDTH   = CoordWidth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [6*CoordWidth-1:0]      s_axis_tdata,  // start_x,y,z, end_x,y,z
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [3*CoordWidth-1:0]      m_axis_tdata,  // point_x, point_y, point_z
  output logic                         m_axis_tuser,  // hit
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]       cfg_index_i,
  input  logic [OffsetWidth-1:0]       cfg_data_i
);

  // products carry twice the coordinate fraction bits on both sides of the
  // divide, so the fixed point format never changes the arithmetic
  // each 32-bit input field contributes its low COORD_WIDTH bits, sign extended

  logic signed [NormWidth-1:0]   normal_x_q, normal_y_q, normal_z_q;
  logic signed [OffsetWidth-1:0] plane_offset_q;
  logic en;
  logic out_valid;
  div_t chain [QuotBits+1];
  logic hit;
  logic signed [CoordWidth-1:0] px, py, pz;

  // whole pipe advances unless a held result blocks the output register
  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      normal_x_q     <= '0;
      normal_y_q     <= '0;
      normal_z_q     <= NormalZReset;
      plane_offset_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegNormalX: normal_x_q     <= cfg_data_i[NormWidth-1:0];
        RegNormalY: normal_y_q     <= cfg_data_i[NormWidth-1:0];
        RegNormalZ: normal_z_q     <= cfg_data_i[NormWidth-1:0];
        RegOffset:  plane_offset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spi_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i       (s_axis_tvalid),
    .start_x_i     (s_axis_tdata[0*CoordWidth +: COORD_WIDTH]),
    .start_y_i     (s_axis_tdata[1*CoordWidth +: COORD_WIDTH]),
    .start_z_i     (s_axis_tdata[2*CoordWidth +: COORD_WIDTH]),
    .end_x_i       (s_axis_tdata[3*CoordWidth +: COORD_WIDTH]),
    .end_y_i       (s_axis_tdata[4*CoordWidth +: COORD_WIDTH]),
    .end_z_i       (s_axis_tdata[5*CoordWidth +: COORD_WIDTH]),
    .normal_x_i    (normal_x_q),
    .normal_y_i    (normal_y_q),
    .normal_z_i    (normal_z_q),
    .plane_offset_i(plane_offset_q),
    .out_o         (chain[0])
  );

  // one quotient bit per cell, msb first
  for (genvar g = 0; g < QuotBits; g++) begin : g_div
    spi_div_cell u_cell (.clk_i, .rst_ni, .en_i(en), .in_i(chain[g]), .out_o(chain[g+1]));
  end

  spi_back u_back (
    .clk_i, .rst_ni, .en_i(en), .in_i(chain[QuotBits]),
    .valid_o(out_valid), .hit_o(hit),
    .point_x_o(px), .point_y_o(py), .point_z_o(pz)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = hit;
  assign m_axis_tdata  = {pz, py, px};

`ifndef SYNTHESIS
  // a miss always carries zero coordinates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss with nonzero point");
  // a stalled beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
  // input ready follows the output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");
`endif

endmodule
